// ----- rtl/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants of the histogram smoothing chain
// Field widths, bin count, log and divide constants, the configuration
// register set and the per-bin sideband that travels with each bin.
// ----------------------------------------------------------------------------
package hsc_pkg;

   // Histogram geometry
   localparam int BIN_COUNT = 256;
   localparam int BIN_W     = $clog2(BIN_COUNT);
   // Tick index runs past the last bin while the trailing bins flush
   localparam int TICK_W    = BIN_W + 1;

   // Field widths
   localparam int CHANNEL_W = 4;
   localparam int COUNT_W   = 24;
   localparam int INDEX_W   = 8;
   localparam int VALUE_W   = 32;
   localparam int SEL_W     = 5;
   localparam int SUM_W     = VALUE_W + 4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SEL_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOG_ON,
      CSR_MEAN_ON,
      CSR_MEDIAN_ON,
      CSR_SEL_CHANNEL
   } csr_index_type;

   // Selection code that keeps every channel (-1 in five bits)
   localparam logic [SEL_W-1:0] SEL_ALL = '1;

   typedef struct packed {
      logic             log_on;
      logic             mean_on;
      logic             median_on;
      logic [SEL_W-1:0] selected_channel;
   } cfg_type;

   // Sideband of one kept bin on its way through the log unit
   typedef struct packed {
      logic                 log_on;
      logic [CHANNEL_W-1:0] channel;
      logic [BIN_W-1:0]     bin;
   } item_meta_type;

   // Bin and tick landmarks
   localparam logic [BIN_W-1:0]  BIN_FIRST         = '0;
   localparam logic [BIN_W-1:0]  BIN_LAST          = BIN_W'(BIN_COUNT - 1);
   localparam logic [TICK_W-1:0] TICK_OUT_FIRST    = TICK_W'(4);
   localparam logic [TICK_W-1:0] TICK_OUT_LAG      = TICK_W'(4);
   localparam logic [TICK_W-1:0] TICK_MEDIAN_FIRST = TICK_W'(6);
   localparam logic [TICK_W-1:0] TICK_MEAN_LAST    = TICK_W'(BIN_COUNT - 1);
   localparam logic [TICK_W-1:0] TICK_MEDIAN_LAST  = TICK_W'(BIN_COUNT + 1);
   localparam logic [TICK_W-1:0] TICK_FLUSH_BASE   = TICK_W'(BIN_COUNT + 4);
   localparam logic [TICK_W-1:0] OUT_BIN_LAST      = TICK_W'(BIN_COUNT - 1);

   // Trailing bins emitted after the last input bin
   localparam int               FLUSH_W     = 3;
   localparam logic [FLUSH_W-1:0] FLUSH_TICKS = FLUSH_W'(4);

   // Log unit: 16 fraction bits from repeated squaring, ln 2 in Q0.32
   localparam int              LOG_N_W     = 5;
   localparam int              LN_FRAC_W   = 16;
   localparam int              LN_L2_W     = LOG_N_W + LN_FRAC_W;
   localparam int              LN_PROD_W   = LN_L2_W + 32;
   localparam int              LN_RES_W    = 13;
   localparam logic [31:0]     LN2_Q32     = 32'd2977044472;
   localparam logic [LN_PROD_W-1:0] LN_ROUND = LN_PROD_W'(1) << 39;

   // Divide by 13 of a value below 13 * 2^16: (v * M) >> 24 is exact
   localparam int              MEAN_DIV      = 13;
   localparam int              DIV_DIGIT_W   = 16;
   localparam int              DIV_IN_W      = DIV_DIGIT_W + 4;
   localparam logic [20:0]     DIV13_MUL     = 21'd1290556;

endpackage

// ----- rtl/hsc_log_pipe.sv -----
// ----------------------------------------------------------------------------
// hsc_log_pipe: natural log unit, fully pipelined
// Finds the leading one, normalizes the count to Q1.31, squares it sixteen
// times (one square per stage) for the fraction bits of log2, then scales
// by ln 2 and rounds to Q24.8. Linear mode passes count << 8.
// ----------------------------------------------------------------------------
module hsc_log_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  hsc_pkg::item_meta_type        in_meta,
   input  logic [hsc_pkg::COUNT_W-1:0]   in_count,
   output logic                          out_valid,
   output hsc_pkg::item_meta_type        out_meta,
   output logic [hsc_pkg::VALUE_W-1:0]   out_value
);
   import hsc_pkg::*;

   typedef struct packed {
      item_meta_type        meta;
      logic [COUNT_W-1:0]   cnt;
      logic [LOG_N_W-1:0]   n;
      logic [VALUE_W-1:0]   x;
      logic [LN_FRAC_W-1:0] frac;
   } sq_stage_type;

   // Index of the leading one, zero for counts of zero and one
   function automatic logic [LOG_N_W-1:0] msb_index(input logic [COUNT_W-1:0] c);
      logic [LOG_N_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < COUNT_W; i++) begin
         if (c[i]) begin
            idx = LOG_N_W'(i);
         end
      end
      return idx;
   endfunction

   // One squaring step: square, keep Q1.31, renormalize on overflow
   function automatic sq_stage_type sq_step(input sq_stage_type s);
      logic [63:0]  prod;
      logic [32:0]  y;
      sq_stage_type r;
      prod   = {32'b0, s.x} * {32'b0, s.x};
      y      = prod[63:31];
      r      = s;
      r.frac = {s.frac[LN_FRAC_W-2:0], y[32]};
      r.x    = y[32] ? y[32:1] : y[31:0];
      return r;
   endfunction

   logic                 ent_valid_ff;
   item_meta_type        ent_meta_ff;
   logic [COUNT_W-1:0]   ent_cnt_ff;

   logic                 lz_valid_ff;
   item_meta_type        lz_meta_ff;
   logic [COUNT_W-1:0]   lz_cnt_ff;
   logic [LOG_N_W-1:0]   lz_n_ff;

   logic                 sq_valid_ff [0:LN_FRAC_W];
   sq_stage_type         sq_ff       [0:LN_FRAC_W];
   sq_stage_type         sq_in       [0:LN_FRAC_W];

   logic                 mul_valid_ff;
   item_meta_type        mul_meta_ff;
   logic [COUNT_W-1:0]   mul_cnt_ff;
   logic [LN_PROD_W-1:0] mul_prod_ff;

   logic [VALUE_W-1:0]   norm_ext;
   logic [LN_L2_W-1:0]   l2;
   logic [LN_PROD_W-1:0] rounded;
   logic [LN_RES_W-1:0]  ln_q8;

   // Normalize into the first squaring stage, then chain the squares
   always_comb begin
      norm_ext       = {{(VALUE_W - COUNT_W){1'b0}}, lz_cnt_ff};
      sq_in[0].meta  = lz_meta_ff;
      sq_in[0].cnt   = lz_cnt_ff;
      sq_in[0].n     = lz_n_ff;
      sq_in[0].x     = norm_ext << (LOG_N_W'(31) - lz_n_ff);
      sq_in[0].frac  = '0;
      for (int i = 0; i < LN_FRAC_W; i++) begin
         sq_in[i+1] = sq_step(sq_ff[i]);
      end
   end

   assign l2 = {sq_ff[LN_FRAC_W].n, sq_ff[LN_FRAC_W].frac};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         lz_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         for (int i = 0; i <= LN_FRAC_W; i++) begin
            sq_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         ent_valid_ff   <= in_valid;
         lz_valid_ff    <= ent_valid_ff;
         sq_valid_ff[0] <= lz_valid_ff;
         for (int i = 0; i < LN_FRAC_W; i++) begin
            sq_valid_ff[i+1] <= sq_valid_ff[i];
         end
         mul_valid_ff   <= sq_valid_ff[LN_FRAC_W];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         ent_meta_ff <= in_meta;
         ent_cnt_ff  <= in_count;
         lz_meta_ff  <= ent_meta_ff;
         lz_cnt_ff   <= ent_cnt_ff;
         lz_n_ff     <= msb_index(ent_cnt_ff);
         for (int i = 0; i <= LN_FRAC_W; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         mul_meta_ff <= sq_ff[LN_FRAC_W].meta;
         mul_cnt_ff  <= sq_ff[LN_FRAC_W].cnt;
         mul_prod_ff <= {32'b0, l2} * {{LN_L2_W{1'b0}}, LN2_Q32};
      end
   end

   // Round to Q24.8 and pick log or linear value
   always_comb begin
      rounded = mul_prod_ff + LN_ROUND;
      ln_q8   = rounded[LN_PROD_W-1:40];
      if (!mul_meta_ff.log_on) begin
         out_value = {mul_cnt_ff, 8'b0};
      end else if (mul_cnt_ff[COUNT_W-1:1] == '0) begin
         out_value = '0;
      end else begin
         out_value = VALUE_W'(ln_q8);
      end
   end

   assign out_valid = mul_valid_ff;
   assign out_meta  = mul_meta_ff;

endmodule

// ----- rtl/hsc_smoother.sv -----
// ----------------------------------------------------------------------------
// hsc_smoother: weighted mean, median, peak and result register
// Turns each kept bin into one tick of the five-tap windows, adds four zero
// ticks after the last bin, and runs the ticks through mean, divide,
// median and peak stages into the result register.
// ----------------------------------------------------------------------------
module hsc_smoother (
   input  logic                            clock,
   input  logic                            reset,
   input  hsc_pkg::cfg_type                cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  hsc_pkg::item_meta_type          in_meta,
   input  logic [hsc_pkg::VALUE_W-1:0]     in_value,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [hsc_pkg::CHANNEL_W-1:0]   rsp_channel,
   output logic [hsc_pkg::INDEX_W-1:0]     rsp_index,
   output logic [hsc_pkg::VALUE_W-1:0]     rsp_value,
   output logic [hsc_pkg::VALUE_W-1:0]     rsp_peak,
   output logic                            rsp_last
);
   import hsc_pkg::*;

   typedef struct packed {
      logic                 has_out;
      logic                 last;
      logic                 median_apply;
      logic [INDEX_W-1:0]   index;
      logic [CHANNEL_W-1:0] channel;
   } tick_info_type;

   // Quotient digit of v / 13 for v below 13 * 2^16
   function automatic logic [DIV_DIGIT_W-1:0] div13_digit(input logic [DIV_IN_W-1:0] v);
      logic [DIV_IN_W+20:0] prod;
      prod = {21'b0, v} * {{DIV_IN_W{1'b0}}, DIV13_MUL};
      return prod[DIV_IN_W+19:24];
   endfunction

   // Median of five by rank: ties broken by position
   function automatic logic [VALUE_W-1:0] median5(input logic [4:0][VALUE_W-1:0] w);
      logic [2:0]         rank;
      logic [VALUE_W-1:0] med;
      med = w[0];
      for (int i = 0; i < 5; i++) begin
         rank = '0;
         for (int j = 0; j < 5; j++) begin
            if (j != i && (w[j] < w[i] || (w[j] == w[i] && j < i))) begin
               rank = rank + 3'd1;
            end
         end
         if (rank == 3'd2) begin
            med = w[i];
         end
      end
      return med;
   endfunction

   logic                      en;
   logic                      busy;
   logic                      take;
   logic                      tick_fire;
   logic [VALUE_W-1:0]        tick_value;
   logic [TICK_W-1:0]         tick_k;
   logic [TICK_W-1:0]         out_bin;
   tick_info_type             tick_info;
   logic                      tick_mean_apply;
   logic [4:0][VALUE_W-1:0]   mean_win_in;
   logic [SUM_W-1:0]          tick_sum;
   logic [CHANNEL_W-1:0]      tick_channel;

   logic [FLUSH_W-1:0]        flush_left_ff, flush_left_in;
   logic [CHANNEL_W-1:0]      cur_channel_ff;
   logic [4:0][VALUE_W-1:0]   mean_win_ff;
   logic [4:0][VALUE_W-1:0]   med_win_ff;
   logic [4:0][VALUE_W-1:0]   med_win_in;
   logic [VALUE_W-1:0]        running_peak_ff;

   logic                      t0_valid_ff;
   logic [SUM_W-1:0]          t0_sum_ff;
   logic [VALUE_W-1:0]        t0_center_ff;
   logic                      t0_apply_ff;
   tick_info_type             t0_info_ff;

   logic                      t1_valid_ff;
   logic [DIV_DIGIT_W-1:0]    t1_qhi_ff;
   logic [3:0]                t1_rhi_ff;
   logic [DIV_DIGIT_W-1:0]    t1_lo_ff;
   logic [VALUE_W-1:0]        t1_center_ff;
   logic                      t1_apply_ff;
   tick_info_type             t1_info_ff;

   logic                      t2_valid_ff;
   logic [VALUE_W-1:0]        t2_mv_ff;
   tick_info_type             t2_info_ff;

   logic                      t3_valid_ff;
   logic [VALUE_W-1:0]        t3_dv_ff;
   tick_info_type             t3_info_ff;

   logic                      rsp_valid_ff;
   logic [CHANNEL_W-1:0]      rsp_channel_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic [VALUE_W-1:0]        rsp_value_ff;
   logic [VALUE_W-1:0]        rsp_peak_ff;
   logic                      rsp_last_ff;

   logic [DIV_IN_W-1:0]       hi_part;
   logic [DIV_DIGIT_W-1:0]    qhi;
   logic [DIV_IN_W-1:0]       rhi_wide;
   logic [DIV_IN_W-1:0]       lo_part;
   logic [DIV_DIGIT_W-1:0]    qlo;
   logic [VALUE_W-1:0]        mv;
   logic [VALUE_W-1:0]        dv;
   logic [VALUE_W-1:0]        peak_new;
   logic                      load_out;

   // Whole chain moves when the result register is free or being taken
   assign en        = !rsp_valid_ff || rsp_ready;
   assign busy      = (flush_left_ff != '0);
   assign in_ready  = en && !busy;
   assign take      = in_ready && in_valid;
   assign tick_fire = en && (busy || in_valid);

   // Build the tick: a real bin or a trailing zero bin
   always_comb begin
      tick_value   = busy ? '0 : in_value;
      tick_k       = busy ? (TICK_FLUSH_BASE - TICK_W'(flush_left_ff)) : TICK_W'(in_meta.bin);
      tick_channel = (take && in_meta.bin == BIN_FIRST) ? in_meta.channel : cur_channel_ff;
      out_bin      = tick_k - TICK_OUT_LAG;
      tick_mean_apply = cfg.mean_on && tick_k >= TICK_OUT_FIRST && tick_k <= TICK_MEAN_LAST;
      tick_info.has_out      = (tick_k >= TICK_OUT_FIRST);
      tick_info.last         = (out_bin == OUT_BIN_LAST);
      tick_info.median_apply = cfg.median_on && tick_k >= TICK_MEDIAN_FIRST
                               && tick_k <= TICK_MEDIAN_LAST;
      tick_info.index        = INDEX_W'(out_bin);
      tick_info.channel      = tick_channel;
      mean_win_in = {tick_value, mean_win_ff[4:1]};
      tick_sum    = SUM_W'(mean_win_in[0]) + SUM_W'(mean_win_in[1]) * SUM_W'(3)
                  + SUM_W'(mean_win_in[2]) * SUM_W'(5) + SUM_W'(mean_win_in[3]) * SUM_W'(3)
                  + SUM_W'(mean_win_in[4]);
   end

   // Count down the trailing bins after the last input bin
   always_comb begin
      flush_left_in = flush_left_ff;
      if (en) begin
         if (busy) begin
            flush_left_in = flush_left_ff - FLUSH_W'(1);
         end else if (take && in_meta.bin == BIN_LAST) begin
            flush_left_in = FLUSH_TICKS;
         end
      end
   end

   // Divide the weighted sum by 13, high digit then low digit
   always_comb begin
      hi_part  = t0_sum_ff[SUM_W-1:DIV_DIGIT_W];
      qhi      = div13_digit(hi_part);
      rhi_wide = hi_part - DIV_IN_W'(qhi) * DIV_IN_W'(MEAN_DIV);
      lo_part  = {t1_rhi_ff, t1_lo_ff};
      qlo      = div13_digit(lo_part);
      mv       = t1_apply_ff ? {t1_qhi_ff, qlo} : t1_center_ff;
   end

   // Median window and peak
   always_comb begin
      med_win_in = {t2_mv_ff, med_win_ff[4:1]};
      dv         = t2_info_ff.median_apply ? median5(med_win_in) : med_win_in[2];
      peak_new   = (running_peak_ff > t3_dv_ff) ? running_peak_ff : t3_dv_ff;
      load_out   = en && t3_valid_ff && t3_info_ff.has_out;
   end

   // Control state and windows
   always_ff @(posedge clock) begin
      if (reset) begin
         flush_left_ff   <= '0;
         cur_channel_ff  <= '0;
         mean_win_ff     <= '0;
         med_win_ff      <= '0;
         running_peak_ff <= '0;
         t0_valid_ff     <= 1'b0;
         t1_valid_ff     <= 1'b0;
         t2_valid_ff     <= 1'b0;
         t3_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         flush_left_ff <= flush_left_in;
         if (take && in_meta.bin == BIN_FIRST) begin
            cur_channel_ff <= in_meta.channel;
         end
         if (tick_fire) begin
            mean_win_ff <= mean_win_in;
         end
         if (en && t2_valid_ff) begin
            med_win_ff <= med_win_in;
         end
         if (load_out) begin
            running_peak_ff <= t3_info_ff.last ? '0 : peak_new;
         end
         if (en) begin
            t0_valid_ff  <= tick_fire;
            t1_valid_ff  <= t0_valid_ff;
            t2_valid_ff  <= t1_valid_ff;
            t3_valid_ff  <= t2_valid_ff;
            rsp_valid_ff <= t3_valid_ff && t3_info_ff.has_out;
         end
      end
   end

   // Tick payload pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         t0_sum_ff    <= tick_sum;
         t0_center_ff <= mean_win_in[2];
         t0_apply_ff  <= tick_mean_apply;
         t0_info_ff   <= tick_info;
         t1_qhi_ff    <= qhi;
         t1_rhi_ff    <= rhi_wide[3:0];
         t1_lo_ff     <= t0_sum_ff[DIV_DIGIT_W-1:0];
         t1_center_ff <= t0_center_ff;
         t1_apply_ff  <= t0_apply_ff;
         t1_info_ff   <= t0_info_ff;
         t2_mv_ff     <= mv;
         t2_info_ff   <= t1_info_ff;
         t3_dv_ff     <= dv;
         t3_info_ff   <= t2_info_ff;
      end
      if (load_out) begin
         rsp_channel_ff <= t3_info_ff.channel;
         rsp_index_ff   <= t3_info_ff.index;
         rsp_value_ff   <= t3_dv_ff;
         rsp_peak_ff    <= t3_info_ff.last ? peak_new : '0;
         rsp_last_ff    <= t3_info_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_index   = rsp_index_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_peak    = rsp_peak_ff;
   assign rsp_last    = rsp_last_ff;

   // The running peak restarts after the last bin of a histogram
   assert property (@(posedge clock) disable iff (reset)
      (load_out && t3_info_ff.last) |=> (running_peak_ff == '0))
      else $error("running peak not cleared after last bin");

   // The peak on the last bin covers that bin's own value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_peak_ff >= rsp_value_ff))
      else $error("peak below last bin value");

   // Only the last bin carries a peak
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_peak_ff == '0))
      else $error("peak on a bin that is not last");

   // Trailing flush starts only after the last bin was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(take && in_meta.bin == BIN_LAST))
      else $error("flush started without a last bin");

endmodule

// ----- rtl/histogram_smoothing_chain.sv -----
// ----------------------------------------------------------------------------
// histogram_smoothing_chain: log, weighted mean and median of histogram bins
// Top level: configuration registers, channel filter, bin counter, log unit
// and smoothing back end.
// ----------------------------------------------------------------------------
// Bins enter one per cycle while req_tready is high, bins 0 to 255 of a
// histogram in order; bins of channels other than the selected one are
// dropped at the input, taking an input cycle but no tick in the back end.
// Each kept bin passes the log unit (leading-one, normalize, sixteen squaring
// stages, ln 2 scaling), then the mean, divide, median and result stages, so
// result bin k follows input bin k+4 through the back end. The last bin of a
// histogram also flushes the four trailing bins: when that bin reaches the
// back end, req_tready drops while the trailing bins run. A result waiting in
// the output register holds the whole chain, and the input with it, until
// rsp_tready takes it. The final result of each histogram has rsp_tlast set
// and carries its peak.
// ----------------------------------------------------------------------------
module histogram_smoothing_chain (
   input  logic                             clock,
   input  logic                             reset,
   // Input bins
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] channel, [27:4] bin_count, [31:28] zero
   input  logic [31:0]                      req_tdata,
   // Smoothed bins
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [3:0] out_channel, [11:4] bin_index, [43:12] bin_value,
   // [75:44] peak_value, [79:76] zero
   output logic [79:0]                      rsp_tdata,
   output logic                             rsp_tlast,
   // Configuration writes
   input  logic                             csr_we,
   input  logic [hsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hsc_pkg::*;

   cfg_type               cfg_ff;
   logic [BIN_W-1:0]      bin_counter_ff;

   logic [CHANNEL_W-1:0]  req_channel;
   logic [COUNT_W-1:0]    req_count;
   logic                  kept;
   logic                  accept;
   item_meta_type         entry_meta;

   logic                  log_valid;
   item_meta_type         log_meta;
   logic [VALUE_W-1:0]    log_value;

   logic [CHANNEL_W-1:0]  rsp_channel;
   logic [INDEX_W-1:0]    rsp_index;
   logic [VALUE_W-1:0]    rsp_value;
   logic [VALUE_W-1:0]    rsp_peak;

   assign req_channel = req_tdata[3:0];
   assign req_count   = req_tdata[27:4];

   // Keep the bin if every channel is selected or its channel matches
   assign kept   = (cfg_ff.selected_channel == SEL_ALL)
                || (cfg_ff.selected_channel == {1'b0, req_channel});
   assign accept = req_tvalid && req_tready;

   assign entry_meta.log_on  = cfg_ff.log_on;
   assign entry_meta.channel = req_channel;
   assign entry_meta.bin     = bin_counter_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_on           <= 1'b0;
         cfg_ff.mean_on          <= 1'b0;
         cfg_ff.median_on        <= 1'b0;
         cfg_ff.selected_channel <= SEL_ALL;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOG_ON:      cfg_ff.log_on           <= csr_wdata[0];
            CSR_MEAN_ON:     cfg_ff.mean_on          <= csr_wdata[0];
            CSR_MEDIAN_ON:   cfg_ff.median_on        <= csr_wdata[0];
            CSR_SEL_CHANNEL: cfg_ff.selected_channel <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Count kept bins, wrap after the last bin
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_counter_ff <= '0;
      end else if (accept && kept) begin
         bin_counter_ff <= (bin_counter_ff == BIN_LAST) ? '0 : bin_counter_ff + BIN_W'(1);
      end
   end

   hsc_log_pipe u_log (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_tready),
      .in_valid  (req_tvalid && kept),
      .in_meta   (entry_meta),
      .in_count  (req_count),
      .out_valid (log_valid),
      .out_meta  (log_meta),
      .out_value (log_value)
   );

   hsc_smoother u_smooth (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (log_valid),
      .in_ready    (req_tready),
      .in_meta     (log_meta),
      .in_value    (log_value),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_channel (rsp_channel),
      .rsp_index   (rsp_index),
      .rsp_value   (rsp_value),
      .rsp_peak    (rsp_peak),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, rsp_peak, rsp_value, rsp_index, rsp_channel};

endmodule
